FILE: hw/rtl/qxm_pkg.sv
package qxm_pkg;

   // field widths
   localparam int InW    = 16;
   localparam int CollW  = 13;
   localparam int CmdW   = 13;
   localparam int ScaleW = 17;
   localparam int QuotW  = 16;
   localparam int MotorN = 4;

   // internal widths: a correction is a sum of three 16-bit terms
   localparam int CorrW = InW + 2;
   // span, divisor and remainder (span below twice the largest correction)
   localparam int SpanW = CorrW + 1;
   // corrections times Q16 scale
   localparam int ProdW = CorrW + ScaleW + 1;
   // collective limits and motor sums
   localparam int AppW  = CorrW + 3;

   localparam logic [ScaleW-1:0] UnitScale = ScaleW'(2**QuotW);

   // X-frame sign table, bits {yaw, pitch, roll}, set where the coefficient is -1
   localparam logic [MotorN-1:0][2:0] CoefNeg = {3'b111, 3'b001, 3'b010, 3'b100};

   typedef logic signed [CorrW-1:0] corr_type;
   typedef corr_type [MotorN-1:0] corr_vec_type;

   // payload carried alongside the divider
   typedef struct packed {
      logic             ok;
      logic [CollW-1:0] coll;
      corr_vec_type     corr;
      logic             shrink;
   } side_type;

   // result held in the output register
   typedef struct packed {
      logic                         result_valid;
      logic [MotorN-1:0][CmdW-1:0]  cmd;
      logic [CmdW-1:0]              applied;
      logic [ScaleW-1:0]            scale;
      logic                         moved;
      logic                         shrunk;
   } rsp_type;

   function automatic corr_type mix_term(logic signed [InW-1:0] x, logic neg);
      corr_type e;
      e = CorrW'(x);
      return neg ? -e : e;
   endfunction

   function automatic corr_type mix_corr(int m, logic signed [InW-1:0] roll,
                                         logic signed [InW-1:0] pitch,
                                         logic signed [InW-1:0] yaw);
      return mix_term(roll, CoefNeg[m][0]) + mix_term(pitch, CoefNeg[m][1])
             + mix_term(yaw, CoefNeg[m][2]);
   endfunction

   function automatic corr_type corr_min(corr_type a, corr_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic corr_type corr_max(corr_type a, corr_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: hw/rtl/qxm_if.sv
// request channel: collective and attitude demands
interface qxm_req_if
   import qxm_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CollW-1:0]        collective;
   logic signed [InW-1:0]   roll;
   logic signed [InW-1:0]   pitch;
   logic signed [InW-1:0]   yaw;

   modport source (output valid, collective, roll, pitch, yaw, input ready);
   modport sink (input valid, collective, roll, pitch, yaw, output ready);
endinterface

// response channel: motor commands and desaturation status
interface qxm_rsp_if
   import qxm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                result_valid;
   logic [CmdW-1:0]     motor_a_command;
   logic [CmdW-1:0]     motor_b_command;
   logic [CmdW-1:0]     motor_c_command;
   logic [CmdW-1:0]     motor_d_command;
   logic [CmdW-1:0]     clamped_collective;
   logic [ScaleW-1:0]   scale_factor;
   logic                collective_moved;
   logic                corrections_shrunk;

   modport source (output valid, result_valid, motor_a_command, motor_b_command,
                   motor_c_command, motor_d_command, clamped_collective, scale_factor,
                   collective_moved, corrections_shrunk, input ready);
   modport sink (input valid, result_valid, motor_a_command, motor_b_command,
                 motor_c_command, motor_d_command, clamped_collective, scale_factor,
                 collective_moved, corrections_shrunk, output ready);
endinterface

FILE: hw/rtl/qxm_mix.sv
module qxm_mix
   import qxm_pkg::*;
#(
   parameter int FULL_SCALE = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  logic [CollW-1:0]       collective,
   input  logic signed [InW-1:0]  roll,
   input  logic signed [InW-1:0]  pitch,
   input  logic signed [InW-1:0]  yaw,
   output logic                   valid_out,
   output side_type               side_out,
   output logic [SpanW-1:0]       span_out
);

   localparam logic [SpanW-1:0] FsSpan = SpanW'(FULL_SCALE);

   // stage 1: per-motor corrections
   logic             v1_ff, ok1_ff, ok1_in;
   logic [CollW-1:0] coll1_ff;
   corr_vec_type     corr1_ff, corr1_in;

   always_comb begin
      ok1_in = SpanW'(collective) <= FsSpan;
      for (int m = 0; m < MotorN; m++) begin
         corr1_in[m] = mix_corr(m, roll, pitch, yaw);
      end
   end

   // stage 2: min and max correction
   logic             v2_ff, ok2_ff;
   logic [CollW-1:0] coll2_ff;
   corr_vec_type     corr2_ff;
   corr_type         mn2_ff, mx2_ff, mn2_in, mx2_in;

   always_comb begin
      mn2_in = corr_min(corr_min(corr1_ff[0], corr1_ff[1]),
                        corr_min(corr1_ff[2], corr1_ff[3]));
      mx2_in = corr_max(corr_max(corr1_ff[0], corr1_ff[1]),
                        corr_max(corr1_ff[2], corr1_ff[3]));
   end

   // stage 3: span and shrink decision
   logic             v3_ff;
   side_type         side3_ff, side3_in;
   logic [SpanW-1:0] span3_ff, span3_in;

   always_comb begin
      span3_in        = SpanW'(mx2_ff) - SpanW'(mn2_ff);
      side3_in.ok     = ok2_ff;
      side3_in.coll   = coll2_ff;
      side3_in.corr   = corr2_ff;
      side3_in.shrink = span3_in > FsSpan;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         ok1_ff   <= ok1_in;
         coll1_ff <= collective;
         corr1_ff <= corr1_in;
         ok2_ff   <= ok1_ff;
         coll2_ff <= coll1_ff;
         corr2_ff <= corr1_ff;
         mn2_ff   <= mn2_in;
         mx2_ff   <= mx2_in;
         side3_ff <= side3_in;
         span3_ff <= span3_in;
      end
   end

   assign valid_out = v3_ff;
   assign side_out  = side3_ff;
   assign span_out  = span3_ff;

endmodule

FILE: hw/rtl/qxm_div.sv
module qxm_div
   import qxm_pkg::*;
#(
   parameter int FULL_SCALE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  side_type          side_in,
   input  logic [SpanW-1:0]  span_in,
   output logic              valid_out,
   output side_type          side_out,
   output logic [QuotW-1:0]  quot_out
);

   // dividend is FULL_SCALE << 16; its upper part seeds the remainder and the
   // low 16 bits are zero, so each stage shifts a zero into the remainder
   localparam logic [SpanW-1:0] RemInit = SpanW'(FULL_SCALE);

   logic             valid_ff [QuotW];
   logic [SpanW-1:0] rem_ff   [QuotW];
   logic [SpanW-1:0] div_ff   [QuotW];
   logic [QuotW-1:0] quot_ff  [QuotW];
   side_type         side_ff  [QuotW];

   for (genvar k = 0; k < QuotW; k++) begin : g_stage
      logic             valid_prev;
      logic [SpanW-1:0] rem_prev, div_prev, trial, rem_in;
      logic [QuotW-1:0] quot_prev, quot_in;
      side_type         side_prev;

      if (k == 0) begin : g_first
         assign valid_prev = valid_in;
         assign rem_prev   = RemInit;
         assign div_prev   = span_in;
         assign quot_prev  = '0;
         assign side_prev  = side_in;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign div_prev   = div_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // one restoring step: one quotient bit, MSB first
      always_comb begin
         trial = {rem_prev[SpanW-2:0], 1'b0};
         if (trial >= div_prev) begin
            rem_in  = trial - div_prev;
            quot_in = {quot_prev[QuotW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_prev[QuotW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            div_ff[k]  <= div_prev;
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign valid_out = valid_ff[QuotW-1];
   assign side_out  = side_ff[QuotW-1];
   assign quot_out  = quot_ff[QuotW-1];

endmodule

FILE: hw/rtl/qxm_sat.sv
module qxm_sat
   import qxm_pkg::*;
#(
   parameter int FULL_SCALE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  side_type          side_in,
   input  logic [QuotW-1:0]  quot_in,
   output logic              valid_out,
   output rsp_type           rsp_out
);

   localparam logic signed [AppW-1:0] FsApp = AppW'(FULL_SCALE);

   // stage 1: pick scale, multiply corrections
   logic                          v1_ff, ok1_ff, shrink1_ff;
   logic [CollW-1:0]              coll1_ff;
   logic [ScaleW-1:0]             scale1_ff, scale1_in;
   logic signed [ProdW-1:0]       prod1_ff [MotorN];
   logic signed [ProdW-1:0]       prod1_in [MotorN];

   always_comb begin
      scale1_in = side_in.shrink ? ScaleW'(quot_in) : UnitScale;
      for (int m = 0; m < MotorN; m++) begin
         prod1_in[m] = $signed(side_in.corr[m]) * $signed({1'b0, scale1_in});
      end
   end

   // stage 2: floor shift, new min and max
   logic              v2_ff, ok2_ff, shrink2_ff;
   logic [CollW-1:0]  coll2_ff;
   logic [ScaleW-1:0] scale2_ff;
   corr_vec_type      corr2_ff, corr2_in;
   corr_type          mn2_ff, mx2_ff, mn2_in, mx2_in;

   always_comb begin
      for (int m = 0; m < MotorN; m++) begin
         corr2_in[m] = prod1_ff[m][CorrW+QuotW-1:QuotW];
      end
      mn2_in = corr_min(corr_min(corr2_in[0], corr2_in[1]),
                        corr_min(corr2_in[2], corr2_in[3]));
      mx2_in = corr_max(corr_max(corr2_in[0], corr2_in[1]),
                        corr_max(corr2_in[2], corr2_in[3]));
   end

   // stage 3: clamp collective into the room left by corrections
   logic                    v3_ff, ok3_ff, shrink3_ff, moved3_ff, moved3_in;
   logic [ScaleW-1:0]       scale3_ff;
   corr_vec_type            corr3_ff;
   logic signed [AppW-1:0]  app3_ff, app3_in, coll_s, lo, hi, lo_clamped;

   always_comb begin
      coll_s     = AppW'(coll2_ff);
      lo         = -AppW'($signed(mn2_ff));
      hi         = FsApp - AppW'($signed(mx2_ff));
      lo_clamped = (coll_s < lo) ? lo : coll_s;
      app3_in    = (lo_clamped > hi) ? hi : lo_clamped;
      moved3_in  = app3_in != coll_s;
   end

   // stage 4: motor sums, clamp, output register
   logic                    v4_ff;
   rsp_type                 rsp4_ff, rsp4_in;
   logic signed [AppW-1:0]  cmd [MotorN];

   always_comb begin
      rsp4_in = '0;
      if (ok3_ff) begin
         rsp4_in.result_valid = 1'b1;
         for (int m = 0; m < MotorN; m++) begin
            cmd[m] = app3_ff + AppW'($signed(corr3_ff[m]));
            if (cmd[m] < 0) begin
               cmd[m] = '0;
            end
            if (cmd[m] > FsApp) begin
               cmd[m] = FsApp;
            end
            rsp4_in.cmd[m] = cmd[m][CmdW-1:0];
         end
         rsp4_in.applied = (app3_ff < 0) ? '0 : app3_ff[CmdW-1:0];
         rsp4_in.scale   = scale3_ff;
         rsp4_in.moved   = moved3_ff;
         rsp4_in.shrunk  = shrink3_ff;
      end else begin
         for (int m = 0; m < MotorN; m++) begin
            cmd[m] = '0;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         ok1_ff     <= side_in.ok;
         shrink1_ff <= side_in.shrink;
         coll1_ff   <= side_in.coll;
         scale1_ff  <= scale1_in;
         for (int m = 0; m < MotorN; m++) begin
            prod1_ff[m] <= prod1_in[m];
         end
         ok2_ff     <= ok1_ff;
         shrink2_ff <= shrink1_ff;
         coll2_ff   <= coll1_ff;
         scale2_ff  <= scale1_ff;
         corr2_ff   <= corr2_in;
         mn2_ff     <= mn2_in;
         mx2_ff     <= mx2_in;
         ok3_ff     <= ok2_ff;
         shrink3_ff <= shrink2_ff;
         scale3_ff  <= scale2_ff;
         corr3_ff   <= corr2_ff;
         app3_ff    <= app3_in;
         moved3_ff  <= moved3_in;
         rsp4_ff    <= rsp4_in;
      end
   end

   assign valid_out = v4_ff;
   assign rsp_out   = rsp4_ff;

endmodule

FILE: hw/rtl/quad_x_motor_mixer_desaturate.sv
// X-frame quad motor mixer with desaturation. Each request carries a collective
// thrust and signed roll, pitch and yaw demands, all scaled so that FULL_SCALE is
// a full command; it returns one response with four motor commands in
// 0..FULL_SCALE, the collective actually applied, the Q16 scale used on the
// corrections (65536 = unscaled) and two status flags. A collective above
// FULL_SCALE gives result_valid = 0 with all other fields zero. The datapath is
// a 23-stage pipeline: 3 stages form the corrections and their span, 16 stages
// of a one-bit-per-stage divider produce the scale, and 4 stages multiply,
// clamp and register the result. A request is taken every cycle unless the
// pipeline is held: the whole pipeline holds while the output register is
// full and not taken; req ready is low only then.
module quad_x_motor_mixer_desaturate
   import qxm_pkg::*;
#(
   parameter int FULL_SCALE = 4096
) (
   input  logic       clock,
   input  logic       reset,
   qxm_req_if.sink    req_chan,
   qxm_rsp_if.source  rsp_chan
);

   logic             en;
   logic             mix_valid, div_valid, sat_valid;
   side_type         mix_side, div_side;
   logic [SpanW-1:0] mix_span;
   logic [QuotW-1:0] div_quot;
   rsp_type          sat_rsp;

   // pipeline advances unless the output register holds an untaken response
   assign en             = !sat_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   qxm_mix #(
      .FULL_SCALE (FULL_SCALE)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .valid_in   (req_chan.valid),
      .collective (req_chan.collective),
      .roll       (req_chan.roll),
      .pitch      (req_chan.pitch),
      .yaw        (req_chan.yaw),
      .valid_out  (mix_valid),
      .side_out   (mix_side),
      .span_out   (mix_span)
   );

   qxm_div #(
      .FULL_SCALE (FULL_SCALE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (mix_valid),
      .side_in   (mix_side),
      .span_in   (mix_span),
      .valid_out (div_valid),
      .side_out  (div_side),
      .quot_out  (div_quot)
   );

   qxm_sat #(
      .FULL_SCALE (FULL_SCALE)
   ) u_sat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (div_valid),
      .side_in   (div_side),
      .quot_in   (div_quot),
      .valid_out (sat_valid),
      .rsp_out   (sat_rsp)
   );

   // response fields
   assign rsp_chan.valid              = sat_valid;
   assign rsp_chan.result_valid       = sat_rsp.result_valid;
   assign rsp_chan.motor_a_command    = sat_rsp.cmd[0];
   assign rsp_chan.motor_b_command    = sat_rsp.cmd[1];
   assign rsp_chan.motor_c_command    = sat_rsp.cmd[2];
   assign rsp_chan.motor_d_command    = sat_rsp.cmd[3];
   assign rsp_chan.clamped_collective = sat_rsp.applied;
   assign rsp_chan.scale_factor       = sat_rsp.scale;
   assign rsp_chan.collective_moved   = sat_rsp.moved;
   assign rsp_chan.corrections_shrunk = sat_rsp.shrunk;

endmodule
